// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the echo core RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hdl/mtfe_pkg.sv =====
// ---------------------------------------------------------------------------
// mtfe_pkg
// Types and fixed constants of the multi-tap feedback echo core.
// ---------------------------------------------------------------------------
`default_nettype none

package mtfe_pkg;

   localparam int GAIN_W      = 16;     // Q1.15 gains
   localparam int GAIN_FRAC   = 15;
   localparam int LEN_W       = 17;     // delay length register
   localparam int RESET_DELAY = 9600;   // 150 ms at 32 kHz stereo
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_IDX_W-1:0] REG_TAP_GAIN_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_GAIN_1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_GAIN_2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_GAIN_3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FEEDBACK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY_LEN   = 3'd5;

   // ring port control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ring_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/multi_tap_feedback_echo_core.sv =====
// ---------------------------------------------------------------------------
// multi_tap_feedback_echo_core
// Four-tap feedback echo over a ring of interleaved stereo samples.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/tready      req_tdata: sample_in
//  rsp      out  rsp_tvalid/tready      rsp_tdata: sample_out
//  csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
//  Each word passes four steps: accept + ring read, tap-gain multiply,
//  feedback multiply, write-back. The single ring port keeps the read
//  and the write-back of a word apart; each multiply has its own step.
//  A new word is taken while a result still waits in the output register;
//  write-back stalls only while that register is still full.
//  Reset is synchronous; the ring needs no clearing pass (fill count).
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multi_tap_feedback_echo_core #(
   parameter int MAX_DELAY   = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // req_tdata: [SAMPLE_BITS-1:0] sample_in, zero padded to bytes
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   // rsp_tdata: [SAMPLE_BITS-1:0] sample_out, zero padded to bytes
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [mtfe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [mtfe_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mtfe_pkg::*;

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int ADDR_W  = $clog2(MAX_DELAY);
   localparam int GSUM_W  = GAIN_W + 2;
   localparam int ACC_W   = GSUM_W + SAMPLE_BITS;
   localparam int ECHO_W  = ACC_W - GAIN_FRAC;
   localparam int FBP_W   = GAIN_W + ECHO_W;
   localparam int FB_W    = FBP_W - GAIN_FRAC;
   localparam int SUM_W   = FB_W + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_FB   = 2'd2;
   localparam logic [1:0] ST_WB   = 2'd3;

   function automatic logic [SAMPLE_BITS-1:0] sat_fn(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-SAMPLE_BITS:0] hi_bits;
      hi_bits = v[SUM_W-1:SAMPLE_BITS-1];
      if ((&hi_bits) || !(|hi_bits)) begin
         return v[SAMPLE_BITS-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   // configuration
   logic signed [GAIN_W-1:0] tap_gain_ff [4];
   logic signed [GAIN_W-1:0] fb_gain_ff;
   logic [LEN_W-1:0]         delay_len_ff;
   logic signed [GSUM_W-1:0] gsum_ff;
   logic signed [GSUM_W-1:0] gsum_in;

   // datapath
   logic [1:0]                    state_ff;
   logic [1:0]                    state_in;
   logic [ADDR_W-1:0]             pos_ff;
   logic [ADDR_W-1:0]             pos_in;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [ACC_W-1:0]       acc_in;
   logic signed [FBP_W-1:0]       fbp_ff;
   logic signed [FBP_W-1:0]       fbp_in;
   logic signed [ECHO_W-1:0]      echo;
   logic signed [FB_W-1:0]        fb;
   logic [SAMPLE_BITS-1:0]        y_ff;
   logic [SAMPLE_BITS-1:0]        w_val;
   logic signed [SAMPLE_BITS-1:0] e_val;
   logic [SAMPLE_BITS-1:0]        ring_rd;
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        rsp_data_ff;
   logic                          req_go;
   logic                          wb_go;
   logic [ADDR_W:0]               pos_inc;
   logic [LEN_W-1:0]              len_eff;
   ring_ctl_type                  ring_ctl;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_go     = req_tvalid && req_tready;
   assign wb_go      = (state_ff == ST_WB) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            tap_gain_ff[i] <= '0;
         end
         fb_gain_ff   <= '0;
         delay_len_ff <= LEN_W'(RESET_DELAY);
         gsum_ff      <= '0;
      end else begin
         gsum_ff <= gsum_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TAP_GAIN_0: tap_gain_ff[0] <= csr_wdata[GAIN_W-1:0];
               REG_TAP_GAIN_1: tap_gain_ff[1] <= csr_wdata[GAIN_W-1:0];
               REG_TAP_GAIN_2: tap_gain_ff[2] <= csr_wdata[GAIN_W-1:0];
               REG_TAP_GAIN_3: tap_gain_ff[3] <= csr_wdata[GAIN_W-1:0];
               REG_FEEDBACK:   fb_gain_ff     <= csr_wdata[GAIN_W-1:0];
               REG_DELAY_LEN:  delay_len_ff   <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // all taps see the same entry, so the four products fold into one
   assign gsum_in = GSUM_W'(tap_gain_ff[0]) + GSUM_W'(tap_gain_ff[1])
                  + GSUM_W'(tap_gain_ff[2]) + GSUM_W'(tap_gain_ff[3]);

   assign e_val  = ring_rd;
   assign acc_in = gsum_ff * e_val;
   assign echo   = acc_ff[ACC_W-1:GAIN_FRAC];   // floor shift
   assign fbp_in = fb_gain_ff * echo;
   assign fb     = fbp_ff[FBP_W-1:GAIN_FRAC];
   assign w_val  = sat_fn(SUM_W'(x_ff) + SUM_W'(fb));

   assign pos_inc = {1'b0, pos_ff} + 1'b1;
   assign len_eff = (delay_len_ff > LEN_W'(MAX_DELAY)) ? LEN_W'(MAX_DELAY) : delay_len_ff;

   always_comb begin
      pos_in = pos_ff;
      if (wb_go) begin
         if (LEN_W'(pos_inc) >= len_eff) begin
            pos_in = '0;
         end else begin
            pos_in = pos_inc[ADDR_W-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_FB;
         ST_FB:   state_in = ST_WB;
         ST_WB: begin
            if (wb_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ring_ctl.rd_en = req_go;
      ring_ctl.wr_en = wb_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         if (wb_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         x_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (state_ff == ST_MUL) begin
         acc_ff <= acc_in;
      end
      if (state_ff == ST_FB) begin
         fbp_ff <= fbp_in;
         y_ff   <= sat_fn(SUM_W'(x_ff) + SUM_W'(echo));
      end
      if (wb_go) begin
         rsp_data_ff <= y_ff;
      end
   end

   mtfe_ring #(
      .DEPTH  (MAX_DELAY),
      .DATA_W (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ring_ctl),
      .addr    (pos_ff),
      .wr_data (w_val),
      .rd_data (ring_rd)
   );

   `ASSERT_PROP(a_accept_starts_mul, clock, reset, req_go |=> (state_ff == ST_MUL),
                "accepted word did not enter multiply")
   `ASSERT_PROP(a_rsp_from_wb, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WB),
                "result raised outside write-back")
   `ASSERT_PROP(a_pos_step, clock, reset,
                wb_go |=> ((pos_ff == '0) || (pos_ff == ADDR_W'($past(pos_ff) + 1'b1))),
                "position neither advanced nor wrapped")

endmodule

`default_nettype wire

// ===== hdl/mtfe_ring.sv =====
// ---------------------------------------------------------------------------
// mtfe_ring
// Delay ring: single-port synchronous memory with a fill count. Entries at
// or above the fill count have not been written since reset and read as zero.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mtfe_ring #(
   parameter int DEPTH  = 65536,
   parameter int DATA_W = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  mtfe_pkg::ring_ctl_type     ctl,
   input  wire  [$clog2(DEPTH)-1:0]   addr,
   input  wire  [DATA_W-1:0]          wr_data,
   output logic [DATA_W-1:0]          rd_data
);
   import mtfe_pkg::*;

   localparam int AW     = $clog2(DEPTH);
   localparam int FILL_W = AW + 1;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_q_ff;
   logic              hit_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] addr_ext;

   assign addr_ext = {1'b0, addr};

   // positions only advance by one or wrap to zero, so the written set is
   // always a prefix [0, fill)
   always_comb begin
      fill_in = fill_ff;
      if (ctl.wr_en && (addr_ext == fill_ff)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= mem[addr];
         hit_ff  <= (addr_ext < fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign rd_data = hit_ff ? rd_q_ff : '0;

   `ASSERT_NEVER(a_ring_rd_wr_same_cycle, clock, reset, ctl.rd_en && ctl.wr_en,
                 "ring read and write in the same cycle")
   `ASSERT_PROP(a_ring_wr_in_prefix, clock, reset, ctl.wr_en |-> (addr_ext <= fill_ff),
                "ring write beyond fill count")
   `ASSERT_PROP(a_ring_fill_bound, clock, reset, fill_ff <= FILL_W'(DEPTH),
                "ring fill count above depth")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-tap feedback echo core. A shadow ring
// predicts each output sample. Directed words cover saturation, gain and
// length extremes. Random traffic follows, with idle and stall patterns on
// both streams and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;
   import mtfe_pkg::*;

   localparam int MAX_DELAY     = 65536;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 500000;

   // indexes the core must ignore
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow state of the core
   logic signed [15:0] echo_ring [MAX_DELAY];
   int unsigned        ring_pos;
   logic signed [15:0] tap_gain [4];
   logic signed [15:0] fb_gain;
   int unsigned        ring_len;

   logic signed [15:0] expected_out [$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   logic hold_toggle = 1'b0;
   logic hold_ack    = 1'b0;
   int   hold_left   = 0;

   always #5 clock = ~clock;

   multi_tap_feedback_echo_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] sample_in
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] sample_out
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic logic signed [15:0] sat16(input longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return 16'(v);
   endfunction

   // output sample for one input word; advances the shadow ring
   function automatic logic signed [15:0] echo_sample(input logic signed [15:0] x);
      longint tap_sum;
      longint echo;
      longint fb;
      logic signed [15:0] e;
      logic signed [15:0] y;
      int unsigned lim;
      e = echo_ring[ring_pos];
      tap_sum = 0;
      foreach (tap_gain[k]) tap_sum += longint'(tap_gain[k]) * longint'(e);
      echo = tap_sum >>> GAIN_FRAC;
      fb = (longint'(fb_gain) * echo) >>> GAIN_FRAC;
      y = sat16(longint'(x) + echo);
      echo_ring[ring_pos] = sat16(longint'(x) + fb);
      lim = (ring_len > MAX_DELAY) ? MAX_DELAY : ring_len;
      ring_pos = (ring_pos + 1 >= lim) ? 0 : ring_pos + 1;
      return y;
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(511)) - 16'd256;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_gain();
      if ($urandom_range(1)) return 16'($urandom);
      return 16'($urandom_range(16383)) - 16'd8192;
   endfunction

   function automatic logic [16:0] rand_length();
      case ($urandom_range(19))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(131071, 65537));
         3, 4: return 17'($urandom_range(4096, 1));
         default: return 17'($urandom_range(64, 1));
      endcase
   endfunction

   // valid is left high after acceptance; the next call or a drain decides
   task automatic send_sample(input logic [15:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      expected_out.push_back(echo_sample(s));
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      // let the last write-back land in the ring
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [16:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_TAP_GAIN_0: tap_gain[0] = val[15:0];
         REG_TAP_GAIN_1: tap_gain[1] = val[15:0];
         REG_TAP_GAIN_2: tap_gain[2] = val[15:0];
         REG_TAP_GAIN_3: tap_gain[3] = val[15:0];
         REG_FEEDBACK:   fb_gain     = val[15:0];
         REG_DELAY_LEN:  ring_len    = val;
         default: ;
      endcase
   endtask

   // gains get a random bit 16, which the core must drop
   task automatic program_echo(input logic [15:0] g0, input logic [15:0] g1,
                               input logic [15:0] g2, input logic [15:0] g3,
                               input logic [15:0] fb, input logic [16:0] len);
      write_reg(REG_UNUSED_6, 17'($urandom));
      write_reg(REG_TAP_GAIN_0, {1'($urandom), g0});
      write_reg(REG_TAP_GAIN_1, {1'($urandom), g1});
      write_reg(REG_TAP_GAIN_2, {1'($urandom), g2});
      write_reg(REG_TAP_GAIN_3, {1'($urandom), g3});
      write_reg(REG_FEEDBACK, {1'($urandom), fb});
      write_reg(REG_DELAY_LEN, len);
      write_reg(REG_UNUSED_7, 17'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'h0000);
      send_sample(16'hffff);
      send_sample(16'h5555);
      send_sample(16'haaaa);
      wait_all_results();
   endtask

   task automatic test_saturation_extremes();
      // full positive gains, full negative feedback, length 1
      program_echo(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 17'd1);
      send_sample(16'h7fff);
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'h8000);
      send_sample(16'h0001);
      wait_all_results();
      // zero length behaves as one
      program_echo(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 17'd0);
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'hffff);
      send_sample(16'h0000);
      wait_all_results();
   endtask

   task automatic test_length_limits();
      // above the store size acts as the full store
      program_echo(16'h2000, 16'he000, 16'h1000, 16'h0800, 16'h4000, 17'h1ffff);
      send_sample(16'h1234);
      send_sample(16'hedcb);
      send_sample(16'h7fff);
      wait_all_results();
      program_echo(16'h4000, 16'h2000, 16'h1000, 16'h0800, 16'hc000, 17'd6);
      repeat (5) send_sample(rand_sample());
      wait_all_results();
      // length now equal to the position: after the next word it wraps to the start
      program_echo(16'h4000, 16'h2000, 16'h1000, 16'h0800, 16'hc000, 17'd2);
      repeat (2) send_sample(rand_sample());
      wait_all_results();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int chunks);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (chunks) begin
         program_echo(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                      rand_length());
         repeat ($urandom_range(55, 30)) send_sample(rand_sample());
         wait_all_results();
      end
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_echo(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(), 17'd16);
      hold_toggle <= ~hold_toggle;
      repeat (40) send_sample(rand_sample());
      wait_all_results();
   endtask

   // receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_toggle != hold_ack) begin
         hold_ack   <= hold_toggle;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      logic signed [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_out.size() == 0) begin
            $display("%0t: sample_out expected none, got %0d", $time,
                     $signed(rsp_tdata));
            error_count++;
         end else begin
            want = expected_out.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: sample_out expected %0d, got %0d", $time, want,
                        $signed(rsp_tdata));
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      foreach (echo_ring[i]) echo_ring[i] = '0;
      foreach (tap_gain[k]) tap_gain[k] = '0;
      fb_gain  = '0;
      ring_len = RESET_DELAY;
      ring_pos = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_saturation_extremes();
      test_length_limits();
      test_random_traffic(24, 52, 8);
      test_random_traffic(52, 24, 8);
      test_random_traffic(0, 0, 8);
      test_output_backpressure();

      wait_all_results();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mtfe_pkg.sv
hdl/mtfe_ring.sv
hdl/multi_tap_feedback_echo_core.sv
tb/tb_top.sv
